// ===== hdl/stgr_pkg.sv =====
// ----------------------------------------------------------------------------
// stgr_pkg: status text glyph renderer shared definitions
// Row sizes, sequencer program, font lookup and state codes.
// ----------------------------------------------------------------------------
package stgr_pkg;

    localparam int ROW_CHARS = 21;
    localparam int POS_W     = $clog2(ROW_CHARS);
    localparam int LEN_W     = $clog2(ROW_CHARS + 1);
    localparam int DIG_N     = 12;
    localparam int DIG_W     = $clog2(DIG_N);
    localparam int PC_W      = 6;

    localparam logic [PC_W-1:0] CALIB_START = 6'd25;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_ZERO  = 7'h30;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_MUL, ST_REM, ST_POP, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_LIT, OP_NUM, OP_SIGN, OP_END
    } op_kind_t;

    typedef enum logic [2:0] {
        FS_PACK, FS_SOC, FS_TEMP, FS_CUR, FS_RAIL
    } fsel_t;

    typedef struct packed {
        op_kind_t   kind;
        logic       row;
        logic [6:0] ch;
        fsel_t      fsel;
    } op_t;

    typedef logic [4:0][6:0] glyph_t;

    function automatic op_t mk_lit(logic row, logic [6:0] ch);
        op_t o;
        o.kind = OP_LIT;
        o.row  = row;
        o.ch   = ch;
        o.fsel = FS_PACK;
        return o;
    endfunction

    function automatic op_t mk_fld(op_kind_t kind, logic row, fsel_t fsel);
        op_t o;
        o.kind = kind;
        o.row  = row;
        o.ch   = CH_SPACE;
        o.fsel = fsel;
        return o;
    endfunction

    // formatting program, normal rows first, then the calibrating message
    function automatic op_t prog_op(logic [PC_W-1:0] pc);
        op_t o;
        case (pc)
            6'd0:  o = mk_fld(OP_NUM, 1'b0, FS_PACK);
            6'd1:  o = mk_lit(1'b0, 7'h56);
            6'd2:  o = mk_lit(1'b0, CH_SPACE);
            6'd3:  o = mk_lit(1'b0, 7'h53);
            6'd4:  o = mk_lit(1'b0, 7'h4F);
            6'd5:  o = mk_lit(1'b0, 7'h43);
            6'd6:  o = mk_lit(1'b0, CH_SPACE);
            6'd7:  o = mk_fld(OP_NUM, 1'b0, FS_SOC);
            6'd8:  o = mk_lit(1'b0, 7'h25);
            6'd9:  o = mk_lit(1'b0, CH_SPACE);
            6'd10: o = mk_lit(1'b0, 7'h54);
            6'd11: o = mk_fld(OP_SIGN, 1'b0, FS_TEMP);
            6'd12: o = mk_fld(OP_NUM, 1'b0, FS_TEMP);
            6'd13: o = mk_lit(1'b0, 7'h43);
            6'd14: o = mk_lit(1'b1, 7'h49);
            6'd15: o = mk_lit(1'b1, CH_SPACE);
            6'd16: o = mk_fld(OP_SIGN, 1'b1, FS_CUR);
            6'd17: o = mk_fld(OP_NUM, 1'b1, FS_CUR);
            6'd18: o = mk_lit(1'b1, 7'h41);
            6'd19: o = mk_lit(1'b1, CH_SPACE);
            6'd20: o = mk_lit(1'b1, 7'h53);
            6'd21: o = mk_lit(1'b1, CH_SPACE);
            6'd22: o = mk_fld(OP_NUM, 1'b1, FS_RAIL);
            6'd23: o = mk_lit(1'b1, 7'h56);
            6'd25: o = mk_lit(1'b0, 7'h43);
            6'd26: o = mk_lit(1'b0, 7'h41);
            6'd27: o = mk_lit(1'b0, 7'h4C);
            6'd28: o = mk_lit(1'b0, 7'h49);
            6'd29: o = mk_lit(1'b0, 7'h42);
            6'd30: o = mk_lit(1'b0, 7'h52);
            6'd31: o = mk_lit(1'b0, 7'h41);
            6'd32: o = mk_lit(1'b0, 7'h54);
            6'd33: o = mk_lit(1'b0, 7'h49);
            6'd34: o = mk_lit(1'b0, 7'h4E);
            6'd35: o = mk_lit(1'b0, 7'h47);
            6'd36: o = mk_lit(1'b0, CH_DOT);
            6'd37: o = mk_lit(1'b0, CH_DOT);
            6'd38: o = mk_lit(1'b0, CH_DOT);
            default: o = mk_fld(OP_END, 1'b0, FS_PACK);
        endcase
        return o;
    endfunction

    function automatic glyph_t glyph_of(logic [6:0] ch);
        glyph_t g;
        case (ch)
            7'h25: g = {7'h23, 7'h13, 7'h08, 7'h64, 7'h62};
            7'h2B: g = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
            7'h2D: g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
            7'h2E: g = {7'h00, 7'h00, 7'h60, 7'h60, 7'h00};
            7'h30: g = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
            7'h31: g = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
            7'h32: g = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
            7'h33: g = {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
            7'h34: g = {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
            7'h35: g = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
            7'h36: g = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
            7'h37: g = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
            7'h38: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
            7'h39: g = {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
            7'h41: g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
            7'h43: g = {7'h22, 7'h41, 7'h41, 7'h41, 7'h3E};
            7'h49: g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
            7'h4F: g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
            7'h53: g = {7'h31, 7'h49, 7'h49, 7'h49, 7'h46};
            7'h56: g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
            7'h42: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h7F};
            7'h47: g = {7'h7A, 7'h49, 7'h49, 7'h41, 7'h3E};
            7'h4C: g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F};
            7'h4E: g = {7'h7F, 7'h08, 7'h04, 7'h02, 7'h7F};
            7'h52: g = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F};
            7'h54: g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== hdl/stgr_div10.sv =====
// ----------------------------------------------------------------------------
// stgr_div10: shared divide-by-ten unit
// Reciprocal multiply registered, then quotient and remainder from the product.
// ----------------------------------------------------------------------------
module stgr_div10 (
    input  logic        aclk,
    input  logic [31:0] val,
    output logic [31:0] quo,
    output logic [3:0]  rem
);
    import stgr_pkg::*;

    localparam logic [31:0] RECIP = 32'hCCCCCCCD;

    logic [63:0] prod_reg;
    logic [31:0] quo_x10;

    always_ff @(posedge aclk) begin
        prod_reg <= {32'd0, val} * {32'd0, RECIP};
    end

    // val must hold steady for the cycle after the product is taken
    assign quo     = {3'd0, prod_reg[63:35]};
    assign quo_x10 = (quo << 3) + (quo << 1);
    assign rem     = 4'(val - quo_x10);

endmodule

// ===== hdl/status_text_glyph_renderer_core.sv =====
// ----------------------------------------------------------------------------
// status_text_glyph_renderer_core: snapshot to two rows of glyph items
// Formats measurements into text with one shared divide-by-ten unit.
// ----------------------------------------------------------------------------
//  channel | ports        | carries
//  input   | s_valid/ready| one measurement snapshot
//  result  | m_valid/ready| one glyph per character, 2 x ROW_CHARS per snapshot
//
//  each literal is one fetch step, each decimal digit a multiply, remainder and pop
//  step, each dropped rounding digit a multiply and remainder step, each dot a pop
//  step, then each result item is one output step; result stalls add to this
//  s_ready is high only in idle; the block works on one snapshot at a time
//  synchronous active-low reset returns the sequencer to idle
//  a stalled result holds the sequencer; all payloads stay stable
module status_text_glyph_renderer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_pack_millivolts,
    input  logic [23:0] s_rail_millivolts,
    input  logic signed [15:0] s_charge_percent,
    input  logic signed [31:0] s_pack_milliamps,
    input  logic signed [15:0] s_temp_decidegrees,
    input  logic        s_calibrating,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_row_select,
    output logic [4:0]  m_char_pos,
    output logic [6:0]  m_char_code,
    output logic [6:0]  m_glyph_col0,
    output logic [6:0]  m_glyph_col1,
    output logic [6:0]  m_glyph_col2,
    output logic [6:0]  m_glyph_col3,
    output logic [6:0]  m_glyph_col4,
    output logic        m_last_char
);
    import stgr_pkg::*;

    state_t state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;

    logic [23:0] pack_reg, rail_reg;
    logic [15:0] soc_reg, temp_reg;
    logic [31:0] ma_reg;

    logic [31:0] val_reg, val_next;
    logic [1:0]  disc_reg, disc_next;
    logic [1:0]  frac_reg, frac_next;
    logic [3:0]  ndig_reg, ndig_next;
    logic [3:0]  pop_reg, pop_next;
    logic        dot_reg, dot_next;
    logic [3:0]  dig_reg [DIG_N];

    logic [6:0]       buf0_reg [ROW_CHARS];
    logic [6:0]       buf1_reg [ROW_CHARS];
    logic [LEN_W-1:0] len0_reg, len1_reg;

    logic             row_reg, row_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    op_t         op;
    logic        wr_en;
    logic [6:0]  wr_ch;
    logic        dig_wr;
    logic [31:0] quo;
    logic [3:0]  rem;
    logic [3:0]  ndig_inc;
    logic [31:0] temp_mag, cur_mag;
    logic [LEN_W-1:0] len_sel;
    logic [6:0]  out_ch;
    glyph_t      glyph;

    stgr_div10 u_div10 (
        .aclk (aclk),
        .val  (val_reg),
        .quo  (quo),
        .rem  (rem)
    );

    assign op       = prog_op(pc_reg);
    assign ndig_inc = ndig_reg + 4'd1;
    assign temp_mag = {16'd0, temp_reg[15] ? (~temp_reg + 16'd1) : temp_reg};
    assign cur_mag  = ma_reg[31] ? (~ma_reg + 32'd1) : ma_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        val_next   = val_reg;
        disc_next  = disc_reg;
        frac_next  = frac_reg;
        ndig_next  = ndig_reg;
        pop_next   = pop_reg;
        dot_next   = dot_reg;
        row_next   = row_reg;
        pos_next   = pos_reg;
        wr_en      = 1'b0;
        wr_ch      = op.ch;
        dig_wr     = 1'b0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    pc_next    = s_calibrating ? CALIB_START : '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                unique case (op.kind)
                    OP_LIT: begin
                        wr_en   = 1'b1;
                        pc_next = pc_reg + 1'b1;
                    end
                    OP_SIGN: begin
                        if (op.fsel == FS_TEMP) begin
                            wr_en = temp_reg[15];
                            wr_ch = CH_MINUS;
                        end else begin
                            wr_en = 1'b1;
                            wr_ch = ma_reg[31] ? CH_MINUS : CH_PLUS;
                        end
                        pc_next = pc_reg + 1'b1;
                    end
                    OP_NUM: begin
                        ndig_next  = '0;
                        state_next = ST_MUL;
                        case (op.fsel)
                            FS_SOC: begin
                                disc_next = 2'd0;
                                frac_next = 2'd0;
                                if (soc_reg[15]) begin
                                    val_next = 32'd0;
                                end else if (soc_reg > 16'd100) begin
                                    val_next = 32'd100;
                                end else begin
                                    val_next = {16'd0, soc_reg};
                                end
                            end
                            FS_TEMP: begin
                                disc_next = 2'd0;
                                frac_next = 2'd1;
                                val_next  = temp_mag;
                            end
                            FS_CUR: begin
                                disc_next = 2'd1;
                                frac_next = 2'd2;
                                val_next  = cur_mag + 32'd5;
                            end
                            FS_RAIL: begin
                                disc_next = 2'd2;
                                frac_next = 2'd1;
                                val_next  = {8'd0, rail_reg} + 32'd50;
                            end
                            default: begin
                                disc_next = 2'd2;
                                frac_next = 2'd1;
                                val_next  = {8'd0, pack_reg} + 32'd50;
                            end
                        endcase
                    end
                    OP_END: begin
                        row_next   = 1'b0;
                        pos_next   = '0;
                        state_next = ST_OUT;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_MUL: begin
                state_next = ST_REM;
            end
            ST_REM: begin
                val_next = quo;
                if (disc_reg != 2'd0) begin
                    disc_next  = disc_reg - 2'd1;
                    state_next = ST_MUL;
                end else begin
                    dig_wr    = 1'b1;
                    ndig_next = ndig_inc;
                    if (ndig_inc <= {2'd0, frac_reg} ||
                        (quo != 32'd0 && ndig_inc < {2'd0, frac_reg} + 4'd10)) begin
                        state_next = ST_MUL;
                    end else begin
                        pop_next   = ndig_reg;
                        dot_next   = 1'b0;
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                wr_en = 1'b1;
                if (frac_reg != 2'd0 && pop_reg == {2'd0, frac_reg} - 4'd1 && !dot_reg) begin
                    wr_ch    = CH_DOT;
                    dot_next = 1'b1;
                end else begin
                    wr_ch = CH_ZERO | {3'd0, dig_reg[pop_reg]};
                    if (pop_reg == 4'd0) begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = ST_FETCH;
                    end else begin
                        pop_next = pop_reg - 4'd1;
                    end
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (pos_reg == POS_W'(ROW_CHARS - 1)) begin
                        pos_next = '0;
                        row_next = 1'b1;
                        if (row_reg) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        pc_reg   <= pc_next;
        val_reg  <= val_next;
        disc_reg <= disc_next;
        frac_reg <= frac_next;
        ndig_reg <= ndig_next;
        pop_reg  <= pop_next;
        dot_reg  <= dot_next;
        row_reg  <= row_next;
        pos_reg  <= pos_next;
        if (s_valid && s_ready) begin
            pack_reg <= s_pack_millivolts;
            rail_reg <= s_rail_millivolts;
            soc_reg  <= s_charge_percent;
            temp_reg <= s_temp_decidegrees;
            ma_reg   <= s_pack_milliamps;
        end
        if (dig_wr) begin
            dig_reg[ndig_reg[DIG_W-1:0]] <= rem;
        end
    end

    // row text buffers; characters past the row end are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len0_reg <= '0;
            len1_reg <= '0;
        end else if (s_valid && s_ready) begin
            len0_reg <= '0;
            len1_reg <= '0;
        end else if (wr_en) begin
            if (!op.row && len0_reg < LEN_W'(ROW_CHARS)) begin
                buf0_reg[len0_reg[POS_W-1:0]] <= wr_ch;
                len0_reg <= len0_reg + 1'b1;
            end
            if (op.row && len1_reg < LEN_W'(ROW_CHARS)) begin
                buf1_reg[len1_reg[POS_W-1:0]] <= wr_ch;
                len1_reg <= len1_reg + 1'b1;
            end
        end
    end

    assign len_sel = row_reg ? len1_reg : len0_reg;
    assign out_ch  = ({1'b0, pos_reg} >= {1'b0, len_sel}) ? CH_SPACE :
                     (row_reg ? buf1_reg[pos_reg] : buf0_reg[pos_reg]);
    assign glyph   = glyph_of(out_ch);

    assign m_row_select = row_reg;
    assign m_char_pos   = 5'(pos_reg);
    assign m_char_code  = out_ch;
    assign m_glyph_col0 = glyph[0];
    assign m_glyph_col1 = glyph[1];
    assign m_glyph_col2 = glyph[2];
    assign m_glyph_col3 = glyph[3];
    assign m_glyph_col4 = glyph[4];
    assign m_last_char  = row_reg && (pos_reg == POS_W'(ROW_CHARS - 1));

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("result offered while taking input");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len0_reg <= LEN_W'(ROW_CHARS) && len1_reg <= LEN_W'(ROW_CHARS))
        else $error("row length overflow");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_char |=> state_reg == ST_IDLE)
        else $error("last item did not end the snapshot");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pos_reg < POS_W'(ROW_CHARS))
        else $error("character position out of row");

endmodule

// ===== test/status_text_glyph_renderer_core_tb.sv =====
// ----------------------------------------------------------------------------
// status_text_glyph_renderer_core_tb: self-checking bench for the glyph renderer
// Drives measurement snapshots with random gaps and result stalls, predicts the
// two formatted text rows and their glyphs, and checks every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module status_text_glyph_renderer_core_tb;

    localparam int NCH = 21;

    typedef struct {
        logic [23:0]        pack_mv;
        logic [23:0]        rail_mv;
        logic signed [15:0] soc;
        logic signed [31:0] ma;
        logic signed [15:0] temp;
        logic               calib;
    } snapshot_t;

    typedef struct {
        logic       row;
        logic [4:0] pos;
        logic [6:0] code;
        logic [6:0] col [5];
        logic       last;
    } glyph_item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [23:0] s_pack_millivolts;
    logic [23:0] s_rail_millivolts;
    logic signed [15:0] s_charge_percent;
    logic signed [31:0] s_pack_milliamps;
    logic signed [15:0] s_temp_decidegrees;
    logic        s_calibrating;
    logic        m_valid;
    logic        m_ready;
    logic        m_row_select;
    logic [4:0]  m_char_pos;
    logic [6:0]  m_char_code;
    logic [6:0]  m_glyph_col0, m_glyph_col1, m_glyph_col2, m_glyph_col3, m_glyph_col4;
    logic        m_last_char;

    status_text_glyph_renderer_core u_top (.*);

    snapshot_t   pending_snaps [$];
    glyph_item_t expected_glyphs [$];
    int          fail_count;
    int          glyphs_seen;
    int          snaps_sent;
    int          calib_sent;
    bit          hold_off;
    bit          stim_done;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------- predictor ----------------
    typedef logic [6:0] row_t [NCH];

    function automatic void put_ch(ref row_t r, ref int n, input logic [6:0] c);
        if (n < NCH) begin
            r[n] = c;
            n++;
        end
    endfunction

    function automatic void put_num(ref row_t r, ref int n, input longint unsigned v);
        logic [6:0] d [10];
        int k;
        k = 0;
        do begin
            d[k] = 7'(8'h30 + v % 10);
            k++;
            v = v / 10;
        end while (v != 0 && k < 10);
        while (k > 0) begin
            k--;
            put_ch(r, n, d[k]);
        end
    endfunction

    function automatic void put_str(ref row_t r, ref int n, input string s);
        for (int i = 0; i < s.len(); i++) put_ch(r, n, 7'(s[i]));
    endfunction

    function automatic void put_volts(ref row_t r, ref int n, input longint unsigned mv);
        longint unsigned dv;
        dv = (mv + 50) / 100;
        put_num(r, n, dv / 10);
        put_ch(r, n, 7'h2E);
        put_ch(r, n, 7'(8'h30 + dv % 10));
        put_ch(r, n, 7'h56);
    endfunction

    // font columns listed left to right
    function automatic void font_cols(input logic [6:0] c, output logic [6:0] g [5]);
        logic [34:0] f;
        case (c)
            7'h25: f = {7'h62, 7'h64, 7'h08, 7'h13, 7'h23};
            7'h2B: f = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
            7'h2D: f = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
            7'h2E: f = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
            7'h30: f = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
            7'h31: f = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
            7'h32: f = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
            7'h33: f = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
            7'h34: f = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
            7'h35: f = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
            7'h36: f = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
            7'h37: f = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
            7'h38: f = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
            7'h39: f = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
            7'h41: f = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
            7'h43: f = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
            7'h49: f = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
            7'h4F: f = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
            7'h53: f = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
            7'h56: f = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
            7'h42: f = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
            7'h47: f = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
            7'h4C: f = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
            7'h4E: f = {7'h7F, 7'h02, 7'h04, 7'h08, 7'h7F};
            7'h52: f = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
            7'h54: f = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
            default: f = '0;
        endcase
        for (int i = 0; i < 5; i++) g[i] = f[34 - 7*i -: 7];
    endfunction

    task automatic predict_rows(input snapshot_t sn);
        row_t rows [2];
        int   len [2];
        int   socv;
        longint unsigned mag, ca;
        glyph_item_t gi;
        for (int r = 0; r < 2; r++) begin
            len[r] = 0;
            for (int p = 0; p < NCH; p++) rows[r][p] = 7'h20;
        end
        if (sn.calib) begin
            put_str(rows[0], len[0], "CALIBRATING...");
        end else begin
            put_volts(rows[0], len[0], sn.pack_mv);
            put_str(rows[0], len[0], " SOC ");
            socv = sn.soc;
            if (socv < 0) socv = 0;
            if (socv > 100) socv = 100;
            put_num(rows[0], len[0], socv);
            put_str(rows[0], len[0], "% T");
            if (sn.temp[15]) begin
                put_ch(rows[0], len[0], 7'h2D);
                mag = 64'h10000 - longint'($unsigned(sn.temp));
            end else begin
                mag = longint'($unsigned(sn.temp));
            end
            put_num(rows[0], len[0], mag / 10);
            put_ch(rows[0], len[0], 7'h2E);
            put_ch(rows[0], len[0], 7'(8'h30 + mag % 10));
            put_ch(rows[0], len[0], 7'h43);

            put_str(rows[1], len[1], "I ");
            if (sn.ma[31]) begin
                put_ch(rows[1], len[1], 7'h2D);
                mag = 64'h100000000 - longint'($unsigned(sn.ma));
            end else begin
                put_ch(rows[1], len[1], 7'h2B);
                mag = longint'($unsigned(sn.ma));
            end
            ca = (mag + 5) / 10;
            put_num(rows[1], len[1], ca / 100);
            put_ch(rows[1], len[1], 7'h2E);
            put_ch(rows[1], len[1], 7'(8'h30 + (ca / 10) % 10));
            put_ch(rows[1], len[1], 7'(8'h30 + ca % 10));
            put_ch(rows[1], len[1], 7'h41);
            put_str(rows[1], len[1], " S ");
            put_volts(rows[1], len[1], sn.rail_mv);
        end
        for (int r = 0; r < 2; r++) begin
            for (int p = 0; p < NCH; p++) begin
                gi.row  = r[0];
                gi.pos  = 5'(p);
                gi.code = rows[r][p];
                font_cols(rows[r][p], gi.col);
                gi.last = (r == 1 && p == NCH - 1);
                expected_glyphs.push_back(gi);
            end
        end
    endtask

    // ---------------- stimulus ----------------
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_snap(input logic [23:0] p, input logic [23:0] rl,
                            input logic signed [15:0] sc, input logic signed [31:0] a,
                            input logic signed [15:0] t, input logic c);
        snapshot_t sn;
        sn.pack_mv = p;
        sn.rail_mv = rl;
        sn.soc     = sc;
        sn.ma      = a;
        sn.temp    = t;
        sn.calib   = c;
        pending_snaps.push_back(sn);
    endtask

    task automatic add_random_snap();
        logic [23:0] p, rl;
        logic signed [15:0] sc, t;
        logic signed [31:0] a;
        p  = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 60000));
        rl = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 15000));
        sc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 110));
        a  = ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                         : 32'(int'($urandom_range(0, 40000)) - 20000);
        t  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                         : 16'(int'($urandom_range(0, 1200)) - 400);
        add_snap(p, rl, sc, a, t, $urandom_range(0, 9) == 0);
    endtask

    initial begin
        fail_count = 0;
        stim_done  = 1'b0;
        // directed corners
        add_snap(24'd0, 24'd0, 16'sd0, 32'sd0, 16'sd0, 1'b0);
        add_snap(24'hFFFFFF, 24'hFFFFFF, 16'sh7FFF, 32'sh7FFFFFFF, 16'sh7FFF, 1'b0);
        add_snap(24'd12345, 24'd3300, -16'sd5, -32'sd1234, -16'sd1, 1'b0);
        add_snap(24'd49, 24'd50, 16'sd100, 32'sd4, 16'sd5, 1'b0);
        add_snap(24'd50, 24'd149, 16'sd101, 32'sd5, -16'sd9, 1'b0);
        add_snap(24'hFFFFFF, 24'hFFFFFF, 16'sh8000, 32'sh80000000, 16'sh8000, 1'b0);
        add_snap(24'hFFFFFF, 24'hFFFFFF, 16'sd100, 32'sh80000001, -16'sd32767, 1'b0);
        add_snap(24'd0, 24'd0, 16'sd0, 32'sd0, 16'sd0, 1'b1);
        add_snap(24'hFFFFFF, 24'hFFFFFF, 16'shFFFF, 32'shFFFFFFFF, 16'shFFFF, 1'b1);
        add_snap(24'd4199, 24'd5000, 16'sd50, -32'sd5, 16'sd250, 1'b0);
        add_snap(24'd999950, 24'd999949, 16'sd99, 32'sd99995, -16'sd100, 1'b0);
        add_snap(24'h555555, 24'hAAAAAA, 16'sh5555, 32'sh55555555, 16'sh5555, 1'b0);
        add_snap(24'hAAAAAA, 24'h555555, 16'shAAAA, 32'shAAAAAAAA, 16'shAAAA, 1'b0);
        for (int i = 0; i < 100; i++) add_random_snap();
    end

    // ---------------- driver ----------------
    int        send_gap;
    int        ready_gap;
    snapshot_t cur_snap;
    logic      s_ready_q;

    initial s_ready_q = 1'b0;

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_pack_millivolts  = '0;
        s_rail_millivolts  = '0;
        s_charge_percent   = '0;
        s_pack_milliamps   = '0;
        s_temp_decidegrees = '0;
        s_calibrating      = 1'b0;
        send_gap  = 0;
        ready_gap = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready_q) begin
                s_valid <= 1'b0;
                send_gap = gap_len();
            end else if (!s_valid) begin
                // drain pause once, after 40 snapshots have been sent
                hold_off = (snaps_sent == 40 && expected_glyphs.size() != 0);
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!hold_off && pending_snaps.size() != 0) begin
                    cur_snap = pending_snaps.pop_front();
                    s_pack_millivolts  <= cur_snap.pack_mv;
                    s_rail_millivolts  <= cur_snap.rail_mv;
                    s_charge_percent   <= cur_snap.soc;
                    s_pack_milliamps   <= cur_snap.ma;
                    s_temp_decidegrees <= cur_snap.temp;
                    s_calibrating      <= cur_snap.calib;
                    s_valid <= 1'b1;
                end else if (pending_snaps.size() == 0) begin
                    stim_done = 1'b1;
                end
            end
            // result stalls, mostly short with an occasional long one
            if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30) ready_gap = gap_len();
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        glyph_item_t e;
        s_ready_q <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_rows(cur_snap);
                snaps_sent <= snaps_sent + 1;
                if (cur_snap.calib) calib_sent <= calib_sent + 1;
            end
            if (m_valid && m_ready) begin
                glyphs_seen <= glyphs_seen + 1;
                if (expected_glyphs.size() == 0) begin
                    $error("glyph item with nothing expected");
                    fail_count++;
                end else begin
                    e = expected_glyphs.pop_front();
                    if (m_row_select !== e.row) begin
                        $error("row_select exp %0d got %0d", e.row, m_row_select);
                        fail_count++;
                    end
                    if (m_char_pos !== e.pos) begin
                        $error("char_pos exp %0d got %0d", e.pos, m_char_pos);
                        fail_count++;
                    end
                    if (m_char_code !== e.code) begin
                        $error("char_code exp %h got %h", e.code, m_char_code);
                        fail_count++;
                    end
                    if (m_glyph_col0 !== e.col[0]) begin
                        $error("glyph_col0 exp %h got %h", e.col[0], m_glyph_col0);
                        fail_count++;
                    end
                    if (m_glyph_col1 !== e.col[1]) begin
                        $error("glyph_col1 exp %h got %h", e.col[1], m_glyph_col1);
                        fail_count++;
                    end
                    if (m_glyph_col2 !== e.col[2]) begin
                        $error("glyph_col2 exp %h got %h", e.col[2], m_glyph_col2);
                        fail_count++;
                    end
                    if (m_glyph_col3 !== e.col[3]) begin
                        $error("glyph_col3 exp %h got %h", e.col[3], m_glyph_col3);
                        fail_count++;
                    end
                    if (m_glyph_col4 !== e.col[4]) begin
                        $error("glyph_col4 exp %h got %h", e.col[4], m_glyph_col4);
                        fail_count++;
                    end
                    if (m_last_char !== e.last) begin
                        $error("last_char exp %0d got %0d", e.last, m_last_char);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        snaps_sent  = 0;
        calib_sent  = 0;
        glyphs_seen = 0;
        hold_off    = 1'b0;
    end

    // ---------------- end of run ----------------
    initial begin
        wait (stim_done && !s_valid);
        wait (expected_glyphs.size() == 0);
        repeat (200) @(posedge aclk);
        $display("covered %0d snapshots (%0d calibrating), %0d glyph items checked",
                 snaps_sent, calib_sent, glyphs_seen);
        if (fail_count == 0 && expected_glyphs.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
